@@ hw/rtl/iirdf1_pkg.sv @@
// Shared constants, types and microcode ROM for the direct-form-I IIR filter.
package iirdf1_pkg;

  localparam int MAX_ORDER      = 8;
  localparam int SAMPLE_W       = 16;
  localparam int COEF_FRAC_BITS = 24;
  localparam int COEF_W         = 32;
  localparam int ACC_W          = 64;
  localparam int PROD_W         = COEF_W + SAMPLE_W;
  localparam int MODE_W         = 2;
  localparam int IDX_W          = 4;
  localparam int ORD_REG_W      = 4;
  localparam int ORDER_W        = $clog2(MAX_ORDER);
  localparam int TAP_W          = $clog2(2 * MAX_ORDER + 1);
  localparam int STEP_W         = 3;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = ORD_REG_W;

  // stream packing
  localparam int IN_DATA_FIELDS_W = SAMPLE_W + IDX_W + COEF_W;
  localparam int IN_TDATA_W       = ((IN_DATA_FIELDS_W + 7) / 8) * 8;
  localparam int IN_TUSER_W       = MODE_W + 1;
  localparam int OUT_TDATA_W      = ((SAMPLE_W + 7) / 8) * 8;

  // item kinds
  localparam logic [MODE_W-1:0] MODE_SAMPLE  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_COEF_FF = 2'd1;
  localparam logic [MODE_W-1:0] MODE_COEF_FB = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORDER  = 1'd1;
  localparam logic [ORD_REG_W-1:0] ORDER_RESET = 4'd2;

  // program addresses
  localparam logic [STEP_W-1:0] STEP_IDLE   = 3'd0;
  localparam logic [STEP_W-1:0] STEP_COEF   = 3'd1;
  localparam logic [STEP_W-1:0] STEP_PASS   = 3'd2;
  localparam logic [STEP_W-1:0] STEP_MAC    = 3'd3;
  localparam logic [STEP_W-1:0] STEP_DRAIN  = 3'd4;
  localparam logic [STEP_W-1:0] STEP_FINISH = 3'd5;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_WCOEF,
    OP_PASS,
    OP_MAC,
    OP_ACCUM,
    OP_FINISH
  } op_t;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_DISPATCH,
    COND_OUT_FREE,
    COND_MORE_TAPS
  } cond_t;

  typedef struct packed {
    op_t               op;
    cond_t             cond;
    logic [STEP_W-1:0] target;
    logic              hold;    // stay on this step while the condition is false
  } ctrl_word_t;

  function automatic ctrl_word_t ucode_rom(input logic [STEP_W-1:0] step);
    ctrl_word_t w;
    w = '{op: OP_NONE, cond: COND_ALWAYS, target: STEP_IDLE, hold: 1'b0};
    unique case (step)
      STEP_IDLE:   w = '{op: OP_LOAD,   cond: COND_DISPATCH,  target: STEP_IDLE, hold: 1'b1};
      STEP_COEF:   w = '{op: OP_WCOEF,  cond: COND_ALWAYS,    target: STEP_IDLE, hold: 1'b0};
      STEP_PASS:   w = '{op: OP_PASS,   cond: COND_OUT_FREE,  target: STEP_IDLE, hold: 1'b1};
      STEP_MAC:    w = '{op: OP_MAC,    cond: COND_MORE_TAPS, target: STEP_MAC,  hold: 1'b0};
      STEP_DRAIN:  w = '{op: OP_ACCUM,  cond: COND_NEVER,     target: STEP_IDLE, hold: 1'b0};
      STEP_FINISH: w = '{op: OP_FINISH, cond: COND_OUT_FREE,  target: STEP_IDLE, hold: 1'b1};
      default:     w = '{op: OP_NONE,   cond: COND_ALWAYS,    target: STEP_IDLE, hold: 1'b0};
    endcase
    return w;
  endfunction

endpackage

@@ hw/rtl/iir_direct_form_one_filter.sv @@
// Direct-form-I IIR filter driven by a small microcoded sequencer.
// Each filtered sample is computed on the single shared 32x16 MAC, one tap a cycle,
//   taps 0..2N (N = clamped filter_order); a new item is accepted only in the idle step.
// Filtered samples pass the MAC, DRAIN and FINISH steps, pass-through samples the PASS
//   step, both then the output register; coefficient writes take the COEF step and give no output
//   transaction. A stalled out_tready holds the sequencer on its output step.
// Reset (rst_n low, synchronous): sequencer idle, output empty, histories and
//   coefficients zero, enable 0, filter_order 2.
module iir_direct_form_one_filter
  import iirdf1_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // sample_in[15:0], coef_index[19:16],
                                             // coef_value[51:20], zero pad[55:52]
  input  logic [IN_TUSER_W-1:0]  in_tuser,   // mode[1:0], first_in_row[2]
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // sample_out[15:0]
  output logic                   out_tuser,  // saturated[0]
  // configuration
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);
  localparam logic signed [SAMPLE_W-1:0] Y_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] Y_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  // ---------------------------------------------------------------------------
  // Field unpacking of the input transaction
  // ---------------------------------------------------------------------------
  logic [MODE_W-1:0]          in_mode;
  logic                       in_first;
  logic signed [SAMPLE_W-1:0] in_sample;
  logic [IDX_W-1:0]           in_idx;
  logic signed [COEF_W-1:0]   in_coef;

  assign in_mode   = in_tuser[MODE_W-1:0];
  assign in_first  = in_tuser[MODE_W];
  assign in_sample = in_tdata[SAMPLE_W-1:0];
  assign in_idx    = in_tdata[SAMPLE_W +: IDX_W];
  assign in_coef   = in_tdata[SAMPLE_W + IDX_W +: COEF_W];

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  logic [STEP_W-1:0]          pc_r, pc_nxt;
  logic                       enable_r;
  logic [ORD_REG_W-1:0]       order_r;

  logic [MODE_W-1:0]          mode_r;
  logic signed [SAMPLE_W-1:0] x_r;
  logic [IDX_W-1:0]           idx_r;
  logic signed [COEF_W-1:0]   coefv_r;

  logic signed [SAMPLE_W-1:0] xh_r [MAX_ORDER];   // x[n-1] .. x[n-MAX_ORDER]
  logic signed [SAMPLE_W-1:0] yh_r [MAX_ORDER];   // y[n-1] .. y[n-MAX_ORDER]
  logic signed [COEF_W-1:0]   b_r  [MAX_ORDER+1]; // b0 .. bN
  logic signed [COEF_W-1:0]   a_r  [MAX_ORDER];   // a1 .. aN

  logic [TAP_W-1:0]           tap_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic                       prod_neg_r;
  logic                       prod_vld_r;
  logic signed [ACC_W-1:0]    acc_r;

  logic                       out_vld_r;
  logic signed [SAMPLE_W-1:0] out_data_r;
  logic                       out_sat_r;

  // ---------------------------------------------------------------------------
  // Sequencer: fetch the control word, evaluate its jump condition
  // ---------------------------------------------------------------------------
  ctrl_word_t        cw;
  logic              accept;
  logic              out_free;
  logic              more_taps;
  logic              taken;
  logic [STEP_W-1:0] disp_target;
  logic [STEP_W-1:0] jump_target;
  logic [ORD_REG_W-1:0] order_eff;
  logic [TAP_W-1:0]  last_tap;

  assign cw        = ucode_rom(pc_r);
  assign in_tready = (pc_r == STEP_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign out_free  = !out_vld_r || out_tready;

  // order 0 acts as 1, anything above the maximum as the maximum
  always_comb begin
    if (order_r == '0) begin
      order_eff = ORD_REG_W'(1);
    end else if (order_r > ORD_REG_W'(MAX_ORDER)) begin
      order_eff = ORD_REG_W'(MAX_ORDER);
    end else begin
      order_eff = order_r;
    end
  end
  // taps run 0 .. 2N: b0*x, then b(k)*x[n-k] and a(k)*y[n-k] interleaved
  assign last_tap  = TAP_W'(order_eff) << 1;
  assign more_taps = (tap_r != last_tap);

  // multiway dispatch on the incoming item kind
  always_comb begin
    unique case (in_mode) inside
      MODE_COEF_FF, MODE_COEF_FB: disp_target = STEP_COEF;
      MODE_SAMPLE:                disp_target = enable_r ? STEP_MAC : STEP_PASS;
      default:                    disp_target = STEP_IDLE;   // reserved kind, dropped
    endcase
  end

  always_comb begin
    jump_target = cw.target;
    unique case (cw.cond)
      COND_NEVER:     taken = 1'b0;
      COND_ALWAYS:    taken = 1'b1;
      COND_DISPATCH: begin
        taken       = accept;
        jump_target = disp_target;
      end
      COND_OUT_FREE:  taken = out_free;
      COND_MORE_TAPS: taken = more_taps;
      default:        taken = 1'b1;
    endcase
  end

  always_comb begin
    if (taken) begin
      pc_nxt = jump_target;
    end else if (cw.hold) begin
      pc_nxt = pc_r;
    end else begin
      pc_nxt = pc_r + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= STEP_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      order_r  <= ORDER_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ENABLE: enable_r <= cfg_wdata[0];
        CFG_ORDER:  order_r  <= cfg_wdata[ORD_REG_W-1:0];
        default:    ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Item capture
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (cw.op == OP_LOAD && accept) begin
      mode_r  <= in_mode;
      x_r     <= in_sample;
      idx_r   <= in_idx;
      coefv_r <= in_coef;
    end
  end

  // ---------------------------------------------------------------------------
  // Coefficient store. Feedforward slots 0..MAX_ORDER, feedback slots 1..MAX_ORDER;
  // anything else is dropped.
  // ---------------------------------------------------------------------------
  logic ff_wr, fb_wr;
  assign ff_wr = (cw.op == OP_WCOEF) && (mode_r == MODE_COEF_FF) &&
                 (idx_r <= IDX_W'(MAX_ORDER));
  assign fb_wr = (cw.op == OP_WCOEF) && (mode_r == MODE_COEF_FB) &&
                 (idx_r != '0) && (idx_r <= IDX_W'(MAX_ORDER));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= MAX_ORDER; i++) b_r[i] <= '0;
      for (int i = 0; i < MAX_ORDER; i++)  a_r[i] <= '0;
    end else begin
      if (ff_wr) b_r[idx_r] <= coefv_r;
      if (fb_wr) a_r[ORDER_W'(idx_r - IDX_W'(1))] <= coefv_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Tap operand selection and the shared multiplier
  // ---------------------------------------------------------------------------
  logic [ORDER_W-1:0]         tap_k;
  logic [IDX_W-1:0]           b_idx;
  logic signed [COEF_W-1:0]   coef_sel;
  logic signed [SAMPLE_W-1:0] data_sel;
  logic                       tap_fb;
  logic signed [PROD_W-1:0]   prod_nxt;

  assign tap_fb = !tap_r[0] && (tap_r != '0);
  assign tap_k  = tap_r[0] ? tap_r[ORDER_W:1] : (tap_r[ORDER_W:1] - ORDER_W'(1));
  assign b_idx  = tap_r[0] ? (IDX_W'(tap_k) + IDX_W'(1)) : '0;

  always_comb begin
    if (tap_r == '0) begin
      coef_sel = b_r[0];
      data_sel = x_r;
    end else if (tap_r[0]) begin
      coef_sel = b_r[b_idx];
      data_sel = xh_r[tap_k];
    end else begin
      coef_sel = a_r[tap_k];
      data_sel = yh_r[tap_k];
    end
  end

  assign prod_nxt = coef_sel * data_sel;

  // ---------------------------------------------------------------------------
  // Accumulator: product of the previous tap is added while the next one is formed
  // ---------------------------------------------------------------------------
  logic signed [ACC_W-1:0] prod_ext;
  logic signed [ACC_W-1:0] acc_add;
  assign prod_ext = ACC_W'(prod_r);
  assign acc_add  = !prod_vld_r ? '0 : (prod_neg_r ? -prod_ext : prod_ext);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
    end else begin
      unique case (cw.op)
        OP_LOAD:  prod_vld_r <= 1'b0;
        OP_MAC:   prod_vld_r <= 1'b1;
        OP_ACCUM: prod_vld_r <= 1'b0;
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cw.op)
      OP_LOAD: begin
        tap_r <= '0;
        acc_r <= '0;
      end
      OP_MAC: begin
        prod_r     <= prod_nxt;
        prod_neg_r <= tap_fb;
        acc_r      <= acc_r + acc_add;
        tap_r      <= tap_r + TAP_W'(1);
      end
      OP_ACCUM: acc_r <= acc_r + acc_add;
      default:  ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Round half up to Q4.12 and clamp
  // ---------------------------------------------------------------------------
  logic signed [ACC_W-1:0]    rnd;
  logic signed [ACC_W-1:0]    q;
  logic                       in_range;
  logic signed [SAMPLE_W-1:0] y_sat;

  assign rnd      = acc_r + ROUND_BIAS;
  assign q        = rnd >>> COEF_FRAC_BITS;
  assign in_range = (&q[ACC_W-1:SAMPLE_W-1]) || !(|q[ACC_W-1:SAMPLE_W-1]);
  assign y_sat    = in_range ? q[SAMPLE_W-1:0] : (q[ACC_W-1] ? Y_MIN : Y_MAX);

  logic fire_pass, fire_finish, clr_hist;
  assign fire_pass   = (cw.op == OP_PASS)   && out_free;
  assign fire_finish = (cw.op == OP_FINISH) && out_free;
  // a row start clears both histories, only when the sample is really filtered
  assign clr_hist    = (cw.op == OP_LOAD) && accept && (in_mode == MODE_SAMPLE) &&
                       enable_r && in_first;

  // histories shift in full on every filtered sample
  always_ff @(posedge clk) begin
    if (!rst_n || clr_hist) begin
      for (int i = 0; i < MAX_ORDER; i++) begin
        xh_r[i] <= '0;
        yh_r[i] <= '0;
      end
    end else if (fire_finish) begin
      xh_r[0] <= x_r;
      yh_r[0] <= y_sat;
      for (int i = 1; i < MAX_ORDER; i++) begin
        xh_r[i] <= xh_r[i-1];
        yh_r[i] <= yh_r[i-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: holds one finished transaction while the next item is taken
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fire_pass || fire_finish) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire_pass) begin
      out_data_r <= x_r;
      out_sat_r  <= 1'b0;
    end else if (fire_finish) begin
      out_data_r <= y_sat;
      out_sat_r  <= !in_range;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = OUT_TDATA_W'(out_data_r);
  assign out_tuser  = out_sat_r;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  // sequencer never strays outside the program
  a_pc_in_program: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r <= STEP_FINISH)
    else $error("sequencer left the program");

  // tap counter never runs past the last tap of the current order
  a_tap_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (pc_r == STEP_MAC) |-> (tap_r <= last_tap))
    else $error("tap counter overran");

  // a coefficient write never produces an output transaction
  a_coef_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_mode == MODE_COEF_FF || in_mode == MODE_COEF_FB)) |=>
      !$rose(out_vld_r))
    else $error("coefficient write produced a result");

  // a clipped result sits at one of the two range limits
  a_sat_limits: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_sat_r) |-> (out_data_r == Y_MAX || out_data_r == Y_MIN))
    else $error("saturation flag without a clipped value");

endmodule

@@ bench/tb_iir_direct_form_one_filter.sv @@
// Self-checking bench for the direct-form-I IIR filter: predicts every result, filtered or passed through, checks them.
module tb_iir_direct_form_one_filter;
  import iirdf1_pkg::*;

  // Item kind that the filter drops without a trace.
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  // Above one filtered sample at order 8, plus margin; covers a coefficient write still in flight.
  localparam int SETTLE_CYCLES = 24;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int PHASES        = 16;
  localparam int PHASE_ITEMS   = 77;

  localparam longint Y_HI = (longint'(1) << (SAMPLE_W - 1)) - 1;
  localparam longint Y_LO = -Y_HI - 1;

  typedef struct packed {
    logic [SAMPLE_W-1:0] y;
    logic                sat;
  } filtered_t;

  // -------------------------------------------------------------------------
  // Scoreboard: own copy of histories, coefficients and the two registers.
  // note_item() is fed every accepted input transaction and queues the
  // predicted result; check_result() pops it against each output transaction.
  // -------------------------------------------------------------------------
  class iir_df1_scoreboard;
    logic signed [SAMPLE_W-1:0] x_hist [MAX_ORDER];
    logic signed [SAMPLE_W-1:0] y_hist [MAX_ORDER];
    logic signed [COEF_W-1:0]   ff_coef[MAX_ORDER + 1];
    logic signed [COEF_W-1:0]   fb_coef[MAX_ORDER];
    logic                       en;
    logic [ORD_REG_W-1:0]       order;
    filtered_t                  predicted_outputs[$];
    int                         errors;

    function new();
      foreach (x_hist[k]) x_hist[k] = '0;
      foreach (y_hist[k]) y_hist[k] = '0;
      foreach (ff_coef[k]) ff_coef[k] = '0;
      foreach (fb_coef[k]) fb_coef[k] = '0;
      en     = 1'b0;
      order  = ORDER_RESET;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == CFG_ENABLE) en = val[0];
      else order = val;
    endfunction

    function int pending();
      return predicted_outputs.size();
    endfunction

    function void note_item(logic [MODE_W-1:0] mode, logic first, logic [SAMPLE_W-1:0] x_raw,
                            logic [IDX_W-1:0] slot, logic [COEF_W-1:0] c);
      longint                     acc;
      longint                     q;
      int                         n;
      int                         k;
      logic signed [SAMPLE_W-1:0] x;
      filtered_t                  r;
      x = x_raw;
      case (mode)
        MODE_COEF_FF: begin
          if (slot <= MAX_ORDER) ff_coef[slot] = c;
        end
        MODE_COEF_FB: begin
          if (slot >= 1 && slot <= MAX_ORDER) fb_coef[slot - 1] = c;
        end
        MODE_SAMPLE: begin
          if (!en) begin
            // bypass: histories untouched, first_in_row ignored
            r.y   = x_raw;
            r.sat = 1'b0;
          end else begin
            if (first) begin
              foreach (x_hist[i]) x_hist[i] = '0;
              foreach (y_hist[i]) y_hist[i] = '0;
            end
            n = (order == 0) ? 1 : (order > MAX_ORDER) ? MAX_ORDER : int'(order);
            acc = longint'(ff_coef[0]) * longint'(x);
            for (k = 0; k < n; k++) begin
              acc = acc + longint'(ff_coef[k + 1]) * longint'(x_hist[k]);
              acc = acc - longint'(fb_coef[k]) * longint'(y_hist[k]);
            end
            // round half up back to Q4.12, then clip
            acc = acc + (longint'(1) << (COEF_FRAC_BITS - 1));
            q   = acc >>> COEF_FRAC_BITS;
            r.sat = 1'b0;
            if (q > Y_HI) begin
              q     = Y_HI;
              r.sat = 1'b1;
            end else if (q < Y_LO) begin
              q     = Y_LO;
              r.sat = 1'b1;
            end
            r.y = q[SAMPLE_W-1:0];
            // the whole delay line moves, whatever the order in use
            for (k = MAX_ORDER - 1; k > 0; k--) begin
              x_hist[k] = x_hist[k - 1];
              y_hist[k] = y_hist[k - 1];
            end
            x_hist[0] = x;
            y_hist[0] = r.y;
          end
          predicted_outputs.insert(predicted_outputs.size(), r);
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [SAMPLE_W-1:0] got_y, logic got_sat);
      filtered_t want;
      if (predicted_outputs.size() == 0) begin
        $display("%0t: unexpected result: got sample %0d sat %0b", $time,
                 $signed(got_y), got_sat);
        errors++;
        return;
      end
      want = predicted_outputs.pop_front();
      if (got_y !== want.y) begin
        $display("%0t: sample_out mismatch: expected %0d, got %0d", $time,
                 $signed(want.y), $signed(got_y));
        errors++;
      end
      if (got_sat !== want.sat) begin
        $display("%0t: saturated mismatch: expected %0b, got %0b", $time, want.sat, got_sat);
        errors++;
      end
    endfunction
  endclass

  // -------------------------------------------------------------------------
  // DUT and its connections
  // -------------------------------------------------------------------------
  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // sample_in, coef_index, coef_value, zero pad
  logic [IN_TUSER_W-1:0]  in_tuser;   // mode, first_in_row
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // sample_out
  logic                   out_tuser;  // saturated
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  iir_direct_form_one_filter uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  iir_df1_scoreboard sb = new();

  // Idle pattern for the current phase: 0 none, 1 sender, 2 receiver, 3 both.
  int idle_mode = 0;
  int cycles    = 0;

  function automatic int send_idle_pct();
    return (idle_mode == 1) ? 68 : (idle_mode == 3) ? 36 : 0;
  endfunction

  function automatic int recv_stall_pct();
    return (idle_mode == 2) ? 68 : (idle_mode == 3) ? 36 : 0;
  endfunction

  always #2 clk = ~clk;

  // Hard stop: well above the slowest legal run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Receiver back-pressure, changed on the falling edge only.
  always @(negedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(99) >= recv_stall_pct());
  end

  // Output monitor: one result transaction per cycle at most.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata[SAMPLE_W-1:0], out_tuser);
  end

  // Mostly ordinary audio-like values, with rails and small values mixed in.
  function automatic logic [SAMPLE_W-1:0] rand_x();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0: return 16'h7fff;
          1: return 16'h8000;
          2: return 16'h0000;
          default: return 16'hffff;
        endcase
      end
      1, 2: return 16'($urandom_range(1024)) - 16'd512;
      default: return 16'($urandom());
    endcase
  endfunction

  // Coefficients kept mostly small (magnitude up to 0.25) so that histories stay unclipped a while;
  // the odd full-range word drives the output hard into saturation.
  function automatic logic [COEF_W-1:0] rand_coef();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 32'($urandom_range(32'h0080_0000)) - 32'h0040_0000;
    else if (r < 85) return 32'($urandom_range(32'h0400_0000)) - 32'h0200_0000;
    else return $urandom();
  endfunction

  // One input transaction; valid is left high afterwards so back-to-back items
  // need no dip. Gaps are inserted at the start of the next call.
  task automatic push_item(logic [MODE_W-1:0] mode, logic first, logic [SAMPLE_W-1:0] x,
                           logic [IDX_W-1:0] slot, logic [COEF_W-1:0] c);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct()) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {{(IN_TDATA_W - IN_DATA_FIELDS_W){1'b0}}, c, slot, x};
    in_tuser  = {first, mode};
    do @(posedge clk); while (!in_tready);
    sb.note_item(mode, first, x, slot, c);
  endtask

  // Wait for every predicted result, then give an unanswered coefficient
  // write time to retire before the registers are touched.
  task automatic settle();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Both registers; spare bits of the enable write are random (only bit 0 counts).
  task automatic set_regs(logic en, logic [ORD_REG_W-1:0] ord);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = CFG_ENABLE;
    cfg_wdata = {3'($urandom_range(7)), en};
    sb.write_reg(cfg_index, cfg_wdata);
    @(negedge clk);
    cfg_index = CFG_ORDER;
    cfg_wdata = ord;
    sb.write_reg(cfg_index, cfg_wdata);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Random item: mostly samples, then coefficient writes with the odd
  // out-of-range slot, and a few unused-mode items.
  task automatic random_item(output bit counted);
    int                  r;
    logic [MODE_W-1:0]   mode;
    logic                first;
    logic [IDX_W-1:0]    slot;
    logic [COEF_W-1:0]   c;
    r     = $urandom_range(99);
    first = 1'($urandom_range(1));
    slot  = 4'($urandom_range(15));
    c     = $urandom();
    if (r < 65) begin
      mode    = MODE_SAMPLE;
      first   = ($urandom_range(99) < 8);
      counted = 1'b1;
    end else if (r < 80) begin
      mode    = MODE_COEF_FF;
      slot    = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 9)) : 4'($urandom_range(8));
      c       = rand_coef();
      counted = (slot <= MAX_ORDER);
    end else if (r < 95) begin
      mode = MODE_COEF_FB;
      if ($urandom_range(9) == 0)
        slot = ($urandom_range(2) == 0) ? 4'd0 : 4'($urandom_range(15, 9));
      else slot = 4'($urandom_range(8, 1));
      c       = rand_coef();
      counted = (slot >= 1 && slot <= MAX_ORDER);
    end else begin
      mode    = MODE_UNUSED;
      counted = 1'b0;
    end
    push_item(mode, first, rand_x(), slot, c);
  endtask

  initial begin
    int                   p;
    int                   k;
    int                   n;
    int                   done;
    bit                   counted;
    logic                 en;
    logic [ORD_REG_W-1:0] ord;

    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    out_tready = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = CFG_ENABLE;
    cfg_wdata  = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // --- directed: reset settings, filter off -> pure bypass ---
    push_item(MODE_SAMPLE, 1'b1, 16'h7fff, 4'd0, 32'd0);
    push_item(MODE_SAMPLE, 1'b0, 16'h8000, 4'd15, 32'hffff_ffff);
    push_item(MODE_COEF_FF, 1'b0, 16'h0000, 4'd0, 32'h7fff_ffff);  // b0 at its top
    push_item(MODE_COEF_FF, 1'b0, 16'h1234, 4'd9, 32'd123);         // slot past the end
    push_item(MODE_COEF_FB, 1'b0, 16'h0000, 4'd0, 32'h8000_0000);   // feedback slot 0
    push_item(MODE_COEF_FB, 1'b1, 16'hffff, 4'd8, 32'h8000_0000);   // a8 at its bottom
    push_item(MODE_COEF_FF, 1'b0, 16'h0000, 4'd8, 32'h0100_0000);   // b8 = 1.0
    push_item(MODE_UNUSED, 1'b1, 16'h7fff, 4'd0, 32'h7fff_ffff);
    settle();

    // --- directed: full order, clipping at both rails ---
    set_regs(1'b1, 4'd8);
    push_item(MODE_SAMPLE, 1'b1, 16'h7fff, 4'd0, 32'd0);
    push_item(MODE_SAMPLE, 1'b0, 16'h8000, 4'd0, 32'd0);
    push_item(MODE_SAMPLE, 1'b0, 16'h0000, 4'd0, 32'd0);
    push_item(MODE_COEF_FF, 1'b0, 16'h0000, 4'd0, 32'h0100_0000);   // b0 = 1.0
    push_item(MODE_SAMPLE, 1'b1, 16'h0001, 4'd0, 32'd0);            // row start, identity
    push_item(MODE_SAMPLE, 1'b0, 16'hffff, 4'd0, 32'd0);
    push_item(MODE_COEF_FB, 1'b0, 16'h0000, 4'd15, 32'h7fff_ffff);  // ignored
    push_item(MODE_COEF_FF, 1'b0, 16'h0000, 4'd15, 32'h7fff_ffff);  // ignored
    push_item(MODE_SAMPLE, 1'b0, 16'h4000, 4'd0, 32'd0);
    settle();

    // --- directed: order register out of range on both sides ---
    set_regs(1'b1, 4'd0);
    push_item(MODE_SAMPLE, 1'b0, 16'h2000, 4'd0, 32'd0);
    push_item(MODE_SAMPLE, 1'b0, 16'he000, 4'd0, 32'd0);
    settle();
    set_regs(1'b1, 4'd15);
    push_item(MODE_SAMPLE, 1'b0, 16'h7fff, 4'd0, 32'd0);
    push_item(MODE_SAMPLE, 1'b0, 16'h8000, 4'd0, 32'd0);

    // --- random phases: each one a register setting and an idle pattern ---
    for (p = 0; p < PHASES; p++) begin
      settle();
      case (p)
        0: ord = 4'd8;
        1: ord = 4'd1;
        2: ord = 4'd0;
        3: ord = 4'd15;
        4: ord = 4'd4;
        5: ord = 4'd8;
        default: ord = 4'($urandom_range(15));
      endcase
      en = (p % 5 != 4);
      set_regs(en, ord);
      idle_mode = p % 4;

      // often a complete coefficient load first, then data through it
      if ($urandom_range(1) == 1) begin
        n = (ord == 0) ? 1 : (ord > MAX_ORDER) ? MAX_ORDER : int'(ord);
        for (k = 0; k <= n; k++)
          push_item(MODE_COEF_FF, 1'($urandom_range(1)), rand_x(), 4'(k), rand_coef());
        for (k = 1; k <= n; k++)
          push_item(MODE_COEF_FB, 1'($urandom_range(1)), rand_x(), 4'(k), rand_coef());
      end

      done = 0;
      while (done < PHASE_ITEMS) begin
        random_item(counted);
        if (counted) done++;
      end
    end

    settle();
    if (sb.errors == 0 && sb.pending() == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
